// ===== src/bew_pkg.sv =====
// Shared constants and types for the Bezier easing warp.
package bew_pkg;

    // Default number of bisection steps.
    localparam int unsigned BisectStepsDefault = 16;

    // Widths of the payload fields.
    localparam int unsigned TW = 17;
    localparam int unsigned CW = 7;

    // Width of the curve value (127 times the curve, Q0.30).
    localparam int unsigned VW = 38;

    // Q0.30 one.
    localparam logic [30:0] OneQ30 = 31'h4000_0000;

    // Input word as it travels through the pipeline.
    typedef struct packed {
        logic [TW-1:0] t;
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic          ident;
    } t_item;

endpackage

// ===== src/bew_curve.sv =====
// Pipelined evaluation of the curve value times 127 at a parameter s.
// The evaluation takes four register stages; a side payload travels alongside.
module bew_curve #(
    parameter int unsigned PW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [30:0]             i_s30,
    input  logic [bew_pkg::CW-1:0]  i_p1,
    input  logic [bew_pkg::CW-1:0]  i_p2,
    input  logic [PW-1:0]           i_side,
    output logic [bew_pkg::VW-1:0]  o_v,
    output logic [PW-1:0]           o_side
);

    logic [30:0] r_s1, r_u1, r_su, r_ss;
    logic [bew_pkg::CW-1:0] r_p1a, r_p2a, r_p1b, r_p2b;
    logic [30:0] r_uus, r_uss, r_sss;
    logic [bew_pkg::VW-1:0] r_w1, r_w2, r_w3;
    logic [PW-1:0] r_sd1, r_sd2, r_sd3, r_sd4;
    logic [bew_pkg::VW-1:0] r_v;
    logic [61:0] n_su, n_ss, n_uus, n_uss, n_sss;
    logic [30:0] n_u;
    logic [bew_pkg::VW-1:0] n_w1, n_w2, n_w3;

    // Stage one: s*u and s*s.
    always_comb begin
        n_u  = bew_pkg::OneQ30 - i_s30;
        n_su = i_s30 * n_u;
        n_ss = i_s30 * i_s30;
    end

    // Stage two: the three cubic terms.
    always_comb begin
        n_uus = r_su * r_u1;
        n_uss = r_su * r_s1;
        n_sss = r_ss * r_s1;
    end

    // Stage three: weights applied to the terms.
    always_comb begin
        n_w1 = bew_pkg::VW'(r_uus) * bew_pkg::VW'(r_p1b) * bew_pkg::VW'(2'd3);
        n_w2 = bew_pkg::VW'(r_uss) * bew_pkg::VW'(r_p2b) * bew_pkg::VW'(2'd3);
        n_w3 = bew_pkg::VW'(r_sss) * bew_pkg::VW'(7'd127);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= i_s30;
            r_u1  <= n_u;
            r_su  <= n_su[60:30];
            r_ss  <= n_ss[60:30];
            r_p1a <= i_p1;
            r_p2a <= i_p2;
            r_sd1 <= i_side;

            r_uus <= n_uus[60:30];
            r_uss <= n_uss[60:30];
            r_sss <= n_sss[60:30];
            r_p1b <= r_p1a;
            r_p2b <= r_p2a;
            r_sd2 <= r_sd1;

            r_w1  <= n_w1;
            r_w2  <= n_w2;
            r_w3  <= n_w3;
            r_sd3 <= r_sd2;

            // Stage four: sum of the weighted terms.
            r_v   <= r_w1 + r_w2 + r_w3;
            r_sd4 <= r_sd3;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_sd4;

endmodule

// ===== src/bew_step.sv =====
// One bisection step: evaluate x at the midpoint and narrow the interval.
module bew_step #(
    parameter int unsigned STEPS = bew_pkg::BisectStepsDefault
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  bew_pkg::t_item      i_item,
    input  logic [STEPS+1:0]    i_lo,
    input  logic [STEPS+1:0]    i_hi,
    output bew_pkg::t_item      o_item,
    output logic [STEPS+1:0]    o_lo,
    output logic [STEPS+1:0]    o_hi
);

    localparam int unsigned IW = $bits(bew_pkg::t_item);
    localparam int unsigned BW = STEPS + 2;
    localparam int unsigned PW = IW + 3 * BW;

    logic [BW-1:0] n_mid;
    logic [30:0]   n_s30;
    logic [bew_pkg::VW-1:0] w_v;
    logic [PW-1:0] w_side;
    bew_pkg::t_item w_item;
    logic [BW-1:0] w_lo, w_hi, w_mid;
    logic [bew_pkg::VW-1:0] w_target;

    // Midpoint of the interval, widened to Q0.30.
    always_comb begin
        n_mid = BW'(({1'b0, i_lo} + {1'b0, i_hi}) >> 1);
        n_s30 = 31'(n_mid) << (29 - STEPS);
    end

    bew_curve #(.PW(PW)) u_curve (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_s30  (n_s30),
        .i_p1   (i_item.ax),
        .i_p2   (i_item.bx),
        .i_side ({i_item, i_lo, i_hi, n_mid}),
        .o_v    (w_v),
        .o_side (w_side)
    );

    assign {w_item, w_lo, w_hi, w_mid} = w_side;
    assign w_target = (bew_pkg::VW'(w_item.t) * bew_pkg::VW'(7'd127)) << 14;

    // Keep the half of the interval that holds the target.
    assign o_item = w_item;
    assign o_lo   = (w_v < w_target) ? w_mid : w_lo;
    assign o_hi   = (w_v < w_target) ? w_hi : w_mid;

endmodule

// ===== src/bezier_easing_warp.sv =====
// Top level of the cubic Bezier easing warp.
// One word is accepted per cycle while the pipeline is not stalled; results leave
// in order, one per word. Each bisection step is one four-stage curve evaluation,
// the final y evaluation another, then rounding and an output register.
// A stall holds the whole pipeline; nothing is lost or repeated.
module bezier_easing_warp #(
    parameter int unsigned BISECT_STEPS = bew_pkg::BisectStepsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: t_in[16:0], ctrl_ax, ctrl_ay, ctrl_bx, ctrl_by, zero pad.
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: warped_t[16:0], zero pad.
    output logic [23:0] m_axis_tdata
);

    localparam int unsigned BW  = BISECT_STEPS + 2;
    localparam int unsigned LAT = 4 * (BISECT_STEPS + 1) + 1;

    logic w_en;
    logic [LAT-1:0] r_vld;
    bew_pkg::t_item w_it [BISECT_STEPS+1];
    logic [BW-1:0]  w_lo [BISECT_STEPS+1];
    logic [BW-1:0]  w_hi [BISECT_STEPS+1];
    logic [BW-1:0]  w_mid;
    logic [30:0]    w_s30;
    logic [bew_pkg::VW-1:0] w_v;
    bew_pkg::t_item w_fit;
    logic [bew_pkg::VW-1:0] n_qw;
    logic [23:0] n_q, r_q;
    bew_pkg::t_item r_fit;
    logic [23:0] n_y;
    logic [16:0] n_res, r_out;
    logic r_ovld;

    // Whole pipeline advances unless the output register is full and held.
    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    // Unpack the input word and flag an identity curve.
    assign w_it[0] = {s_axis_tdata[16:0], s_axis_tdata[23:17], s_axis_tdata[30:24],
                      s_axis_tdata[37:31], s_axis_tdata[44:38],
                      (s_axis_tdata[23:17] == s_axis_tdata[30:24])
                      && (s_axis_tdata[37:31] == s_axis_tdata[44:38])};
    assign w_lo[0] = '0;
    assign w_hi[0] = BW'(1) << (BISECT_STEPS + 1);

    // Chain of bisection steps.
    for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_step
        bew_step #(.STEPS(BISECT_STEPS)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_item (w_it[g]),
            .i_lo   (w_lo[g]),
            .i_hi   (w_hi[g]),
            .o_item (w_it[g+1]),
            .o_lo   (w_lo[g+1]),
            .o_hi   (w_hi[g+1])
        );
    end

    // Final y evaluation at the last midpoint.
    assign w_mid = BW'(({1'b0, w_lo[BISECT_STEPS]} + {1'b0, w_hi[BISECT_STEPS]}) >> 1);
    assign w_s30 = 31'(w_mid) << (29 - BISECT_STEPS);

    bew_curve #(.PW($bits(bew_pkg::t_item))) u_ycurve (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s30  (w_s30),
        .i_p1   (w_it[BISECT_STEPS].ay),
        .i_p2   (w_it[BISECT_STEPS].by),
        .i_side (w_it[BISECT_STEPS]),
        .o_v    (w_v),
        .o_side (w_fit)
    );

    // Rounding, first half: add half of 127*2^14 and drop the low 14 bits.
    always_comb begin
        n_qw = w_v + bew_pkg::VW'(127 * 8192);
        n_q  = n_qw[37:14];
    end

    // Rounding, second half: floor(q/127) by a reciprocal that never overshoots,
    // one upward correction, saturation to one; an identity curve passes t instead.
    always_comb begin
        logic [47:0] prod;
        logic [23:0] rem;
        prod = 48'(r_q) * 48'd132104;
        n_y  = prod[47:24];
        rem  = r_q - 24'(n_y * 24'd127);
        if (rem >= 24'd127) begin
            n_y = n_y + 24'd1;
        end
        if (r_fit.ident) begin
            n_res = (r_fit.t > 17'd65536) ? 17'd65536 : r_fit.t;
        end else begin
            n_res = (n_y > 24'd65536) ? 17'd65536 : n_y[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q   <= n_q;
            r_fit <= w_fit;
            r_out <= n_res;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[LAT-2:0], s_axis_tvalid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {7'd0, r_out};

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_axis_tready |=> r_ovld && $stable(r_out))
        else $error("held word changed");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_out <= 17'd65536)
        else $error("result above one");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> s_axis_tready)
        else $error("stall without a held word");
`endif

endmodule
